>>> rtl/wildcard_glob_matcher_assert.svh
// Assertion macros for the wildcard glob matcher.
// Depends on clk and rst_n being visible in the including module.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// check a condition at every edge outside reset
`define WGM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("wgm assertion failed");

// antecedent implies consequent in the same cycle
`define WGM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wgm assertion failed");

// antecedent implies consequent in the next cycle
`define WGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wgm assertion failed");

`endif

>>> rtl/wgm_pkg.sv
// Shared types, constants and the case fold for the wildcard glob matcher.
// No dependencies.
package wgm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // broadcast to every cell
  typedef struct packed {
    logic       accept;
    logic       is_text;
    logic [7:0] char_code;
  } cell_ctl_t;

  // per-cell select
  typedef struct packed {
    logic wr_en;
    logic active;
  } cell_sel_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

>>> rtl/wgm_in_if.sv
// Request channel: opcode and character byte with valid/ready.
// Depends on wgm_pkg.
interface wgm_in_if import wgm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;

  modport source (output valid, opcode, char_code, input ready);
  modport sink   (input valid, opcode, char_code, output ready);
endinterface

>>> rtl/wgm_out_if.sv
// Result channel: match and overflow flags with valid/ready.
// No dependencies.
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, matched, overflowed, input ready);
  modport sink   (input valid, matched, overflowed, output ready);
endinterface

>>> rtl/wgm_cell.sv
// One pattern position: stored byte, live bit, and its link in the star chain.
// Depends on wgm_pkg.
module wgm_cell import wgm_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  cell_sel_t sel,
  input  logic      carry_in,
  output logic      carry_out,
  output logic      live
);

  logic [7:0] char_r;
  logic [7:0] char_nxt;
  logic       live_r;
  logic       live_nxt;
  logic       star;
  logic       hit;
  logic       live_act;
  logic       adv;

  assign char_nxt = sel.wr_en ? ctl.char_code : char_r;
  assign star     = (char_nxt == CH_STAR);
  assign hit      = (char_nxt == CH_ANY) ||
                    (fold_char(char_nxt) == fold_char(ctl.char_code));
  assign live_act = ctl.is_text & sel.active & live_r;
  assign adv      = live_act & ~star & hit;
  assign live_nxt = (live_act & star) | carry_in;
  assign carry_out = (sel.active & live_nxt & star) | adv;
  assign live     = live_r;

  always_ff @(posedge clk) begin
    if (sel.wr_en) begin
      char_r <= char_nxt;
    end
    if (ctl.accept) begin
      live_r <= live_nxt;
    end
  end

endmodule

>>> rtl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: length, overflow, cell row, result register.
// Depends on wgm_pkg, wgm_in_if, wgm_out_if, wgm_cell and the assertion macros.
//
//   channel  | dir | fields                 | notes
//   in_req   | in  | opcode, char_code      | clear, append, text byte, end of text
//   out_rsp  | out | matched, overflowed    | one result per end of text
//
// One request per cycle while in_req.ready is high; each text byte updates the live set on acceptance,
// its depth set by the star ripple through the PATTERN_MAX cells.
// An end of text gives its result in the cycle after it is accepted, from an output register.
// in_req.ready is low during reset and while a result waits with out_rsp.ready low.
// Synchronous reset leaves an empty pattern with position zero live.
`include "wildcard_glob_matcher_assert.svh"

module wildcard_glob_matcher import wgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wgm_in_if.sink    in_req,
  wgm_out_if.source out_rsp
);

  logic [LEN_W-1:0]     len_r;
  logic [LEN_W-1:0]     len_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;
  logic                 live_end_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_matched_r;
  logic                 out_ovf_r;
  logic                 in_acc;
  op_t                  op;
  logic                 full;
  cell_ctl_t            ctl;
  cell_sel_t            sel [PATTERN_MAX];
  logic [PATTERN_MAX:0] chain;
  logic [PATTERN_MAX:0] live_vec;

  assign op     = op_t'(in_req.opcode);
  assign in_acc = in_req.valid & in_req.ready;
  assign full   = (len_r == LEN_W'(PATTERN_MAX));
  assign in_req.ready = rst_n & (~out_valid_r | out_rsp.ready);

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (!rst_n) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (in_acc) begin
      case (op)
        OP_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
        end
        OP_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end
  end

  // reset runs the cells through a restart with an empty pattern
  assign ctl.accept    = ~rst_n | in_acc;
  assign ctl.is_text   = rst_n & (op == OP_TEXT);
  assign ctl.char_code = in_req.char_code;
  assign chain[0]      = ~rst_n | (in_acc & (op != OP_TEXT));

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    assign sel[i].wr_en  = rst_n & in_acc & (op == OP_APPEND) & (len_r == LEN_W'(i));
    assign sel[i].active = (LEN_W'(i) < len_nxt);

    wgm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (sel[i]),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .live      (live_vec[i])
    );
  end

  assign live_vec[PATTERN_MAX] = live_end_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && op == OP_END) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      live_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctl.accept) begin
        live_end_r <= chain[PATTERN_MAX];
      end
    end
    if (in_acc && op == OP_END) begin
      out_matched_r <= live_vec[len_r] & ~ovf_r;
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.matched    = out_matched_r;
  assign out_rsp.overflowed = out_ovf_r;

  `WGM_ASSERT_NEXT(a_restart_head, in_acc && op != OP_TEXT, live_vec[0])
  `WGM_ASSERT_ALWAYS(a_live_in_range, ((live_vec >> len_r) >> 1) == '0)
  `WGM_ASSERT_SAME(a_ovf_no_match, out_valid_r && out_ovf_r, !out_matched_r)
  `WGM_ASSERT_NEXT(a_end_result, in_acc && op == OP_END, out_valid_r)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for wildcard_glob_matcher: directed table, then random glob sessions.
// Depends on wgm_pkg, wgm_in_if, wgm_out_if and the wildcard_glob_matcher RTL.
// Expected match/overflow flags per end of text: an in-bench NFA predictor, or the table for typed rows.
module tb import wgm_pkg::*;;

  localparam int N_ITEMS     = 1400;
  localparam int STALL_LIMIT = 200;
  localparam int N_DIR       = 24;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } verdict_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    int         reps;
    bit         typed;
    logic       m;
    logic       o;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  wgm_in_if  in_req ();
  wgm_out_if out_rsp ();

  wildcard_glob_matcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  logic [7:0]       pat_bytes [PATTERN_MAX];
  int               pat_len;
  logic [PATTERN_MAX:0] live;
  logic             pat_ovf;

  verdict_t  expected_verdicts [$];
  stim_row_t dir_rows [N_DIR];

  int n_sent      = 0;
  int n_results   = 0;
  int n_hits      = 0;
  int n_ovf       = 0;
  int n_err       = 0;
  int rsp_hold    = 0;
  int quiet_count = 0;
  bit steady      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic void close_stars();
    for (int i = 0; i < pat_len; i++) begin
      if (live[i] && pat_bytes[i] == CH_STAR) begin
        live[i + 1] = 1'b1;
      end
    end
  endfunction

  function automatic void restart_live();
    live    = '0;
    live[0] = 1'b1;
    close_stars();
  endfunction

  function automatic void step_matcher(input op_t op, input logic [7:0] ch,
                                       output bit has_result, output verdict_t v);
    logic [PATTERN_MAX:0] nxt;
    v          = '0;
    has_result = 1'b0;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        restart_live();
      end
      OP_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        restart_live();
      end
      OP_TEXT: begin
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (live[i]) begin
            if (pat_bytes[i] == CH_STAR) begin
              nxt[i] = 1'b1;
            end else if (pat_bytes[i] == CH_ANY ||
                         fold_lower(pat_bytes[i]) == fold_lower(ch)) begin
              nxt[i + 1] = 1'b1;
            end
          end
        end
        live = nxt;
        close_stars();
      end
      default: begin
        v.matched    = live[pat_len] && !pat_ovf;
        v.overflowed = pat_ovf;
        has_result   = 1'b1;
        restart_live();
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(0, 7))
      0: return "a";
      1: return "A";
      2: return "b";
      3: return "B";
      4: return CH_STAR;
      5: return CH_ANY;
      6: return "z";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_req(input op_t op, input logic [7:0] ch, input bit typed,
                          input logic tm, input logic to);
    int       gap;
    bit       got;
    verdict_t v;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.opcode    <= op;
    in_req.char_code <= ch;
    do @(posedge clk); while (!in_req.ready);
    step_matcher(op, ch, got, v);
    if (got) begin
      if (typed) begin
        v = '{matched: tm, overflowed: to};
      end
      expected_verdicts.push_back(v);
    end
    n_sent++;
  endtask

  task automatic run_session();
    logic [7:0] plan [$];
    logic [7:0] text [$];
    logic [7:0] c;
    int         r;
    int         len;
    int         idx;
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(5, 15)) begin
        send_req(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      end
      return;
    end
    if ($urandom_range(0, 9) != 0) begin
      send_req(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = $urandom_range(0, 6);
    end else if (r < 92) begin
      len = $urandom_range(7, PATTERN_MAX);
    end else begin
      len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
    end
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        c = CH_STAR;
      end else if (r < 35) begin
        c = CH_ANY;
      end else if (r < 85) begin
        c = pick_glyph();
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      plan.push_back(c);
      send_req(OP_APPEND, c, 1'b0, 1'b0, 1'b0);
    end
    repeat ($urandom_range(1, 3)) begin
      text.delete();
      foreach (plan[i]) begin
        c = plan[i];
        if (c == CH_STAR) begin
          repeat ($urandom_range(0, 2)) text.push_back(pick_glyph());
        end else if (c == CH_ANY) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 1) == 1 && fold_lower(c) >= "a" && fold_lower(c) <= "z") begin
            c = c ^ 8'h20;
          end
          text.push_back(c);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        idx = (text.size() > 0) ? $urandom_range(0, text.size() - 1) : 0;
        case ($urandom_range(0, 2))
          0: if (text.size() > 0) text.delete(idx);
          1: text.insert(idx, pick_glyph());
          default: if (text.size() > 0) text[idx] = pick_glyph();
        endcase
      end
      foreach (text[i]) send_req(OP_TEXT, text[i], 1'b0, 1'b0, 1'b0);
      send_req(OP_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      n_results++;
      if (out_rsp.matched) n_hits++;
      if (out_rsp.overflowed) n_ovf++;
      if (expected_verdicts.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected result: matched=%0b overflowed=%0b",
                   out_rsp.matched, out_rsp.overflowed);
        end
      end else begin
        if (out_rsp.matched !== expected_verdicts[0].matched ||
            out_rsp.overflowed !== expected_verdicts[0].overflowed) begin
          n_err++;
          if (n_err <= 10) begin
            $display("result %0d: matched exp %0b got %0b, overflowed exp %0b got %0b",
                     n_results, expected_verdicts[0].matched, out_rsp.matched,
                     expected_verdicts[0].overflowed, out_rsp.overflowed);
          end
        end
        void'(expected_verdicts.pop_front());
      end
      rsp_hold = steady ? 0 : $urandom_range(0, 3);
    end else if (rsp_hold > 0) begin
      rsp_hold--;
    end
    out_rsp.ready <= (rsp_hold == 0);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_count);
        $display("wildcard_glob_matcher: mismatch");
        $finish;
      end
    end
  end

  initial begin
    dir_rows = '{
      '{OP_END,    8'h00,   1,  1'b1, 1'b1, 1'b0},
      '{OP_TEXT,   8'hFF,   1,  1'b0, 1'b0, 1'b0},
      '{OP_END,    8'h00,   1,  1'b1, 1'b0, 1'b0},
      '{OP_APPEND, "A",     1,  1'b0, 1'b0, 1'b0},
      '{OP_APPEND, CH_ANY,  1,  1'b0, 1'b0, 1'b0},
      '{OP_APPEND, CH_STAR, 1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   "a",     1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   CH_STAR, 1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   8'h00,   1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   "Y",     1,  1'b0, 1'b0, 1'b0},
      '{OP_END,    8'h5A,   1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   "a",     1,  1'b0, 1'b0, 1'b0},
      '{OP_APPEND, "[",     1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   "a",     1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   CH_ANY,  1,  1'b0, 1'b0, 1'b0},
      '{OP_TEXT,   "{",     1,  1'b0, 1'b0, 1'b0},
      '{OP_END,    8'h00,   1,  1'b0, 1'b0, 1'b0},
      '{OP_CLEAR,  8'hFF,   1,  1'b0, 1'b0, 1'b0},
      '{OP_APPEND, CH_STAR, 1,  1'b0, 1'b0, 1'b0},
      '{OP_END,    8'h00,   1,  1'b0, 1'b0, 1'b0},
      '{OP_APPEND, "z",     40, 1'b0, 1'b0, 1'b0},
      '{OP_END,    8'hFF,   1,  1'b1, 1'b0, 1'b1},
      '{OP_CLEAR,  8'h00,   1,  1'b0, 1'b0, 1'b0},
      '{OP_END,    8'hA5,   1,  1'b1, 1'b1, 1'b0}
    };
    pat_bytes        = '{default: 8'h00};
    pat_len          = 0;
    pat_ovf          = 1'b0;
    restart_live();
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.opcode    <= OP_CLEAR;
    in_req.char_code <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      repeat (dir_rows[i].reps) begin
        send_req(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].typed,
                 dir_rows[i].m, dir_rows[i].o);
      end
    end
    while (n_sent < N_ITEMS) run_session();

    in_req.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("sent %0d requests; checked %0d end-of-text results (%0d matched, %0d overflowed)",
             n_sent, n_results, n_hits, n_ovf);
    if (n_err == 0) begin
      $display("wildcard_glob_matcher: match");
    end else begin
      $display("%0d mismatches", n_err);
      $display("wildcard_glob_matcher: mismatch");
    end
    $finish;
  end

endmodule
